/* hw/rtl/mcim_pkg.sv */
// ----------------------------------------------------------------------------
// mcim_pkg
// Shared constants, register map and types of the motor current monitor.
// ----------------------------------------------------------------------------
package mcim_pkg;

  // Channel count and PWM timing
  localparam int JOINTS     = 2;
  localparam int JOINT_W    = 1;
  localparam int PWM_FULL   = 1000;
  localparam int DEAD_COUNT = 40;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int DUTY_W   = 12;
  localparam int CUR_W    = 21;
  localparam int MAG_W    = 20;
  localparam int ACC_W    = 31;
  localparam int LIMIT_W  = 16;
  localparam int FACTOR_W = 16;
  localparam int JIDX_W   = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // Duty scaling: k = DIVIDEND / (duty - 2*DEAD_COUNT)
  localparam int DIVIDEND     = PWM_FULL * 16;
  localparam int QUO_W        = $clog2(DIVIDEND + 1);
  localparam int DIV_CNT_W    = $clog2(QUO_W + 1);
  localparam int DEAD2        = 2 * DEAD_COUNT;
  localparam int LOW_DUTY_MAX = DEAD2 + 20;

  localparam int CUR_MAX          = 1048575;
  localparam int ACC_MAX          = 2147483647;
  localparam int LOW_DUTY_CURRENT = 500;
  localparam int OFFSET_SKIP      = 15;
  localparam int OFFSET_RESET     = 3376;
  localparam int A1_Q16           = 64789;
  localparam int A2_Q8            = 1459;

  // Shared multiplier
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // Register map
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FACTOR = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd2;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd7000;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd30147;
  localparam logic                MODE_LPF     = 1'b0;
  localparam logic                MODE_I2T     = 1'b1;

  typedef struct packed {
    logic [LIMIT_W-1:0]  current_limit;
    logic [FACTOR_W-1:0] conversion_factor;
    logic                accumulate_mode;
  } cfg_t;

endpackage

/* hw/rtl/mcim_in_if.sv */
// ----------------------------------------------------------------------------
// mcim_in_if
// Sample channel: valid/ready handshake with one converter sample per transaction.
// ----------------------------------------------------------------------------
interface mcim_in_if;
  logic                              valid;
  logic                              ready;
  logic [mcim_pkg::JOINT_W-1:0]      joint;
  logic [mcim_pkg::SAMPLE_W-1:0]     adc_sample;
  logic                              positive_dir;
  logic [mcim_pkg::DUTY_W-1:0]       duty;

  modport source (output valid, joint, adc_sample, positive_dir, duty, input ready);
  modport sink   (input valid, joint, adc_sample, positive_dir, duty, output ready);
endinterface

/* hw/rtl/mcim_out_if.sv */
// ----------------------------------------------------------------------------
// mcim_out_if
// Result channel: valid/ready handshake with one result per transaction.
// ----------------------------------------------------------------------------
interface mcim_out_if;
  logic                                valid;
  logic                                ready;
  logic [mcim_pkg::JOINT_W-1:0]        joint_out;
  logic signed [mcim_pkg::CUR_W-1:0]   current_ma;
  logic [mcim_pkg::ACC_W-1:0]          accumulated;
  logic                                offset_valid;

  modport source (output valid, joint_out, current_ma, accumulated, offset_valid,
                  input ready);
  modport sink   (input valid, joint_out, current_ma, accumulated, offset_valid,
                  output ready);
endinterface

/* hw/rtl/mcim_regs.sv */
// ----------------------------------------------------------------------------
// mcim_regs
// APB-style configuration registers: current limit, conversion factor, mode.
// ----------------------------------------------------------------------------
module mcim_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcim_pkg::ADDR_W-1:0]   paddr,
  input  logic [mcim_pkg::DATA_W-1:0]   pwdata,
  output logic [mcim_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mcim_pkg::cfg_t                cfg
);

  logic                              wr_en;
  logic [mcim_pkg::REG_IDX_W-1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[mcim_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.current_limit     <= mcim_pkg::LIMIT_RESET;
      cfg.conversion_factor <= mcim_pkg::FACTOR_RESET;
      cfg.accumulate_mode   <= mcim_pkg::MODE_LPF;
    end else if (wr_en) begin
      unique case (reg_idx)
        mcim_pkg::REG_LIMIT:  cfg.current_limit     <= pwdata[mcim_pkg::LIMIT_W-1:0];
        mcim_pkg::REG_FACTOR: cfg.conversion_factor <= pwdata[mcim_pkg::FACTOR_W-1:0];
        mcim_pkg::REG_MODE:   cfg.accumulate_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      mcim_pkg::REG_LIMIT:  prdata = mcim_pkg::DATA_W'(cfg.current_limit);
      mcim_pkg::REG_FACTOR: prdata = mcim_pkg::DATA_W'(cfg.conversion_factor);
      mcim_pkg::REG_MODE:   prdata = mcim_pkg::DATA_W'(cfg.accumulate_mode);
      default:              prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/mcim_div.sv */
// ----------------------------------------------------------------------------
// mcim_div
// Radix-2 restoring divider: constant PWM dividend over the effective duty.
// ----------------------------------------------------------------------------
module mcim_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mcim_pkg::DUTY_W-1:0]   divisor,
  output logic                          busy,
  output logic [mcim_pkg::QUO_W-1:0]    quotient
);

  logic [mcim_pkg::DUTY_W-1:0]    rem;
  logic [mcim_pkg::DUTY_W-1:0]    dvs;
  logic [mcim_pkg::DIV_CNT_W-1:0] cnt;
  logic [mcim_pkg::DUTY_W:0]      shifted;
  logic [mcim_pkg::DUTY_W:0]      trial;
  logic                           fits;

  assign shifted = {rem, quotient[mcim_pkg::QUO_W-1]};
  assign trial   = shifted - {1'b0, dvs};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= mcim_pkg::DIV_CNT_W'(mcim_pkg::QUO_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == mcim_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // quotient register doubles as the dividend shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= mcim_pkg::QUO_W'(mcim_pkg::DIVIDEND);
    end else if (busy) begin
      rem      <= fits ? trial[mcim_pkg::DUTY_W-1:0] : shifted[mcim_pkg::DUTY_W-1:0];
      quotient <= {quotient[mcim_pkg::QUO_W-2:0], fits};
    end
  end

endmodule

/* hw/rtl/mcim_mul.sv */
// ----------------------------------------------------------------------------
// mcim_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mcim_mul (
  input  logic                         clk,
  input  logic [mcim_pkg::MUL_W-1:0]   a,
  input  logic [mcim_pkg::MUL_W-1:0]   b,
  output logic [mcim_pkg::PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= mcim_pkg::PROD_W'(a) * mcim_pkg::PROD_W'(b);
  end

endmodule

/* hw/rtl/motor_current_i2t_monitor_top.sv */
// ----------------------------------------------------------------------------
// motor_current_i2t_monitor_top
// Per-joint motor current scaling with offset calibration and low-pass or
// i2t accumulation.
// ----------------------------------------------------------------------------
// One sample is handled at a time. A sample with normal duty goes first
// through the bit-serial divider that forms the duty scale factor, then
// through steps on one shared 32x32 multiplier (two products for the
// current, one or two for the accumulator) plus the output step. A low-duty
// sample skips the divider. The input is ready again once the result sits in
// the output register, so a new sample can be accepted in the same cycle as
// the result appears. A result that is not yet taken holds the next one in
// its final step. Configuration writes may be made at any time the block is
// idle.
module motor_current_i2t_monitor_top (
  input  logic                          clk,
  input  logic                          rst,
  mcim_in_if.sink                       in_ch,
  mcim_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcim_pkg::ADDR_W-1:0]   paddr,
  input  logic [mcim_pkg::DATA_W-1:0]   pwdata,
  output logic [mcim_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_A1   = 4'd5;
  localparam logic [3:0] S_A2   = 4'd6;
  localparam logic [3:0] S_A3   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  mcim_pkg::cfg_t cfg;

  logic [3:0] state;

  // per-joint state
  logic [mcim_pkg::SAMPLE_W-1:0] adc_offset     [mcim_pkg::JOINTS];
  logic                          offset_pending [mcim_pkg::JOINTS];
  logic [mcim_pkg::MAG_W-1:0]    last_mag       [mcim_pkg::JOINTS];
  logic [mcim_pkg::ACC_W-1:0]    accumulator    [mcim_pkg::JOINTS];

  // working registers
  logic [mcim_pkg::JIDX_W-1:0]   jidx;
  logic [mcim_pkg::JOINT_W-1:0]  joint_r;
  logic                          pos_r;
  logic [mcim_pkg::SAMPLE_W-1:0] diff;
  logic [mcim_pkg::MAG_W-1:0]    mag;
  logic [47:0]                   t1;
  logic signed [mcim_pkg::CUR_W-1:0] res_cur;
  logic [mcim_pkg::ACC_W-1:0]    res_acc;
  logic                          res_offv;
  logic                          res_update;

  // output register
  logic                              out_valid;
  logic [mcim_pkg::JOINT_W-1:0]      out_joint;
  logic signed [mcim_pkg::CUR_W-1:0] out_cur;
  logic [mcim_pkg::ACC_W-1:0]        out_acc;
  logic                              out_offv;

  // shared units
  logic                          div_start;
  logic                          div_busy;
  logic [mcim_pkg::DUTY_W-1:0]   div_divisor;
  logic [mcim_pkg::QUO_W-1:0]    div_quo;
  logic [mcim_pkg::MUL_W-1:0]    mul_a;
  logic [mcim_pkg::MUL_W-1:0]    mul_b;
  logic [mcim_pkg::PROD_W-1:0]   mul_p;

  // combinational helpers
  logic                          in_fire;
  logic                          in_joint_ok;
  logic [mcim_pkg::JIDX_W-1:0]   in_jidx;
  logic                          latch_off;
  logic [mcim_pkg::SAMPLE_W-1:0] off_use;
  logic                          low_duty;
  logic                          mag_sat;
  logic [mcim_pkg::MAG_W-1:0]    mag_new;
  logic signed [21:0]            e_val;
  logic [mcim_pkg::MAG_W-1:0]    e_abs;
  logic [mcim_pkg::MAG_W:0]      mag_sum;
  logic [36:0]                   i2t_add;
  logic [36:0]                   i2t_sub;
  logic [40:0]                   q_round;
  logic [48:0]                   lpf_sum;
  logic                          out_free;

  mcim_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcim_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  mcim_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_joint_ok = (32'(in_ch.joint) < mcim_pkg::JOINTS);
  assign in_jidx     = mcim_pkg::JIDX_W'(in_ch.joint);
  assign latch_off   = offset_pending[in_jidx]
                       && (in_ch.adc_sample != mcim_pkg::SAMPLE_W'(mcim_pkg::OFFSET_SKIP));
  assign off_use     = latch_off ? in_ch.adc_sample : adc_offset[in_jidx];
  assign low_duty    = (in_ch.duty <= mcim_pkg::DUTY_W'(mcim_pkg::LOW_DUTY_MAX));
  assign div_start   = in_fire && in_joint_ok && !low_duty;
  assign div_divisor = in_ch.duty - mcim_pkg::DUTY_W'(mcim_pkg::DEAD2);

  // current magnitude from diff * factor * k, scaled down by 2^20
  assign mag_sat = |mul_p[mcim_pkg::PROD_W-1:40];
  assign mag_new = mag_sat ? mcim_pkg::MAG_W'(mcim_pkg::CUR_MAX) : mul_p[39:20];

  assign e_val   = signed'(22'(mag)) - signed'(22'(cfg.current_limit));
  assign e_abs   = e_val[21] ? mcim_pkg::MAG_W'(-e_val) : e_val[mcim_pkg::MAG_W-1:0];
  assign mag_sum = (mcim_pkg::MAG_W+1)'(last_mag[jidx]) + (mcim_pkg::MAG_W+1)'(mag);

  assign i2t_add = 37'(accumulator[jidx]) + 37'(mul_p[39:4]);
  assign q_round = 41'(mul_p[39:0]) + 41'(15);
  assign i2t_sub = 37'(accumulator[jidx]) - 37'(q_round[40:4]);
  assign lpf_sum = 49'(t1) + (49'(mul_p[40:0]) << 8);

  assign out_free = !out_valid || out_ch.ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1: begin
        mul_a = mcim_pkg::MUL_W'(diff);
        mul_b = mcim_pkg::MUL_W'(cfg.conversion_factor);
      end
      S_M2: begin
        mul_a = mul_p[mcim_pkg::MUL_W-1:0];
        mul_b = mcim_pkg::MUL_W'(div_quo);
      end
      S_A1: begin
        if (cfg.accumulate_mode == mcim_pkg::MODE_I2T) begin
          mul_a = mcim_pkg::MUL_W'(e_abs);
          mul_b = mcim_pkg::MUL_W'(e_abs);
        end else begin
          mul_a = mcim_pkg::MUL_W'(mcim_pkg::A1_Q16);
          mul_b = mcim_pkg::MUL_W'(accumulator[jidx]);
        end
      end
      S_A2: begin
        mul_a = mcim_pkg::MUL_W'(mcim_pkg::A2_Q8);
        mul_b = mcim_pkg::MUL_W'(mag_sum);
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (!in_joint_ok) begin
              state <= S_DONE;
            end else if (low_duty) begin
              state <= S_A1;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV:  if (!div_busy) state <= S_M1;
        S_M1:   state <= S_M2;
        S_M2:   state <= S_M3;
        S_M3:   state <= S_A1;
        S_A1:   state <= S_A2;
        S_A2: begin
          state <= (cfg.accumulate_mode == mcim_pkg::MODE_I2T) ? S_DONE : S_A3;
        end
        S_A3:   state <= S_DONE;
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          jidx       <= in_jidx;
          joint_r    <= in_ch.joint;
          pos_r      <= in_ch.positive_dir;
          diff       <= (in_ch.adc_sample > off_use) ? in_ch.adc_sample - off_use : '0;
          res_update <= in_joint_ok;
          res_offv   <= in_joint_ok && !(offset_pending[in_jidx] && !latch_off);
          if (!in_joint_ok) begin
            res_cur <= '0;
            res_acc <= '0;
          end else if (low_duty) begin
            // low duty reports a fixed positive current
            mag     <= mcim_pkg::MAG_W'(mcim_pkg::LOW_DUTY_CURRENT);
            res_cur <= mcim_pkg::CUR_W'(mcim_pkg::LOW_DUTY_CURRENT);
          end
        end
      end
      S_M3: begin
        mag     <= mag_new;
        res_cur <= pos_r ? signed'(mcim_pkg::CUR_W'(mag_new))
                         : -signed'(mcim_pkg::CUR_W'(mag_new));
      end
      S_A2: begin
        t1 <= mul_p[47:0];
        if (cfg.accumulate_mode == mcim_pkg::MODE_I2T) begin
          if (!e_val[21] && (e_val != '0)) begin
            res_acc <= (i2t_add > 37'(mcim_pkg::ACC_MAX))
                       ? mcim_pkg::ACC_W'(mcim_pkg::ACC_MAX) : i2t_add[mcim_pkg::ACC_W-1:0];
          end else begin
            // negative result of the subtraction clamps at zero
            res_acc <= i2t_sub[36] ? '0 : i2t_sub[mcim_pkg::ACC_W-1:0];
          end
        end
      end
      S_A3: begin
        res_acc <= (|lpf_sum[48:47]) ? mcim_pkg::ACC_W'(mcim_pkg::ACC_MAX)
                                     : lpf_sum[46:16];
      end
      default: ;
    endcase
  end

  // per-joint state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < mcim_pkg::JOINTS; i++) begin
        adc_offset[i]     <= mcim_pkg::SAMPLE_W'(mcim_pkg::OFFSET_RESET);
        offset_pending[i] <= 1'b1;
        last_mag[i]       <= '0;
        accumulator[i]    <= '0;
      end
    end else begin
      if (in_fire && in_joint_ok && latch_off) begin
        adc_offset[in_jidx]     <= in_ch.adc_sample;
        offset_pending[in_jidx] <= 1'b0;
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
        if (res_update) begin
          last_mag[jidx]    <= mag;
          accumulator[jidx] <= res_acc;
        end
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_joint <= joint_r;
      out_cur   <= res_cur;
      out_acc   <= res_acc;
      out_offv  <= res_offv;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.joint_out    = out_joint;
  assign out_ch.current_ma   = out_cur;
  assign out_ch.accumulated  = out_acc;
  assign out_ch.offset_valid = out_offv;

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor current monitor. Converter samples for
// both joints go in through the sample channel in random bursts, and results
// come back under random back-pressure. A scoreboard keeps its own offset,
// current and accumulator state and checks every result field. A short
// directed part sweeps the extremes of the fields, offset calibration, low
// duty, saturation and both accumulate modes. Random phases with changing
// register settings follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [mcim_pkg::JOINT_W-1:0]  joint;
    logic [mcim_pkg::SAMPLE_W-1:0] adc_sample;
    logic                          positive_dir;
    logic [mcim_pkg::DUTY_W-1:0]   duty;
  } current_sample_t;

  typedef struct packed {
    logic [mcim_pkg::JOINT_W-1:0]       joint;
    logic signed [mcim_pkg::CUR_W-1:0]  current_ma;
    logic [mcim_pkg::ACC_W-1:0]         accumulated;
    logic                               offset_valid;
  } monitor_result_t;

  class i2t_scoreboard;
    logic [mcim_pkg::LIMIT_W-1:0]  limit;
    logic [mcim_pkg::FACTOR_W-1:0] factor;
    logic                          mode;
    logic [mcim_pkg::SAMPLE_W-1:0] offset [mcim_pkg::JOINTS];
    bit                            offset_pending [mcim_pkg::JOINTS];
    longint                        last_ma [mcim_pkg::JOINTS];
    longint                        acc [mcim_pkg::JOINTS];
    monitor_result_t               expected_q [$];
    int                            errors;

    function new();
      limit  = mcim_pkg::LIMIT_RESET;
      factor = mcim_pkg::FACTOR_RESET;
      mode   = mcim_pkg::MODE_LPF;
      errors = 0;
      for (int j = 0; j < mcim_pkg::JOINTS; j++) begin
        offset[j]         = mcim_pkg::SAMPLE_W'(mcim_pkg::OFFSET_RESET);
        offset_pending[j] = 1'b1;
        last_ma[j]        = 0;
        acc[j]            = 0;
      end
    endfunction

    function void write_reg(logic [mcim_pkg::REG_IDX_W-1:0] idx,
                            logic [mcim_pkg::DATA_W-1:0] val);
      case (idx)
        mcim_pkg::REG_LIMIT:  limit  = val[mcim_pkg::LIMIT_W-1:0];
        mcim_pkg::REG_FACTOR: factor = val[mcim_pkg::FACTOR_W-1:0];
        mcim_pkg::REG_MODE:   mode   = val[0];
        default: ;
      endcase
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Signed current in mA; low duty forces a fixed positive value
    function longint scale_to_ma(current_sample_t s, logic [mcim_pkg::SAMPLE_W-1:0] off);
      longint diff, k, mag;
      if (s.duty <= mcim_pkg::LOW_DUTY_MAX)
        return mcim_pkg::LOW_DUTY_CURRENT;
      diff = (s.adc_sample > off) ? longint'(s.adc_sample) - longint'(off) : 0;
      k    = longint'(mcim_pkg::DIVIDEND) / (longint'(s.duty) - longint'(mcim_pkg::DEAD2));
      mag  = (diff * longint'(factor) * k) >>> 20;
      if (mag > mcim_pkg::CUR_MAX)
        mag = mcim_pkg::CUR_MAX;
      return s.positive_dir ? mag : -mag;
    endfunction

    function void note_sample(current_sample_t s);
      monitor_result_t r;
      longint cur, prev_abs, cur_abs, e, q, nxt;
      int j;
      j = int'(s.joint);
      if (offset_pending[j] && s.adc_sample != mcim_pkg::OFFSET_SKIP) begin
        offset[j]         = s.adc_sample;
        offset_pending[j] = 1'b0;
      end
      prev_abs   = magnitude(last_ma[j]);
      cur        = scale_to_ma(s, offset[j]);
      last_ma[j] = cur;
      cur_abs    = magnitude(cur);
      if (mode == mcim_pkg::MODE_LPF) begin
        nxt = (longint'(mcim_pkg::A1_Q16) * acc[j] +
               longint'(mcim_pkg::A2_Q8) * 256 * (prev_abs + cur_abs)) >>> 16;
      end else begin
        e = cur_abs - longint'(limit);
        q = e * e;
        // excess adds floor(e^2/16), headroom removes ceil(e^2/16)
        if (e > 0)
          nxt = acc[j] + (q >>> 4);
        else
          nxt = acc[j] - ((q + 15) >>> 4);
        if (nxt < 0)
          nxt = 0;
      end
      if (nxt > mcim_pkg::ACC_MAX)
        nxt = mcim_pkg::ACC_MAX;
      acc[j] = nxt;
      r.joint        = s.joint;
      r.current_ma   = cur[mcim_pkg::CUR_W-1:0];
      r.accumulated  = nxt[mcim_pkg::ACC_W-1:0];
      r.offset_valid = !offset_pending[j];
      expected_q.push_back(r);
    endfunction

    function void report(string field, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(monitor_result_t got);
      monitor_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got joint %0d current %0d acc %0d",
                 $time, got.joint, got.current_ma, got.accumulated);
        return;
      end
      want = expected_q.pop_front();
      if (got.joint !== want.joint)
        report("joint_out", want.joint, got.joint);
      if (got.current_ma !== want.current_ma)
        report("current_ma", longint'(want.current_ma), longint'(got.current_ma));
      if (got.accumulated !== want.accumulated)
        report("accumulated", want.accumulated, got.accumulated);
      if (got.offset_valid !== want.offset_valid)
        report("offset_valid", want.offset_valid, got.offset_valid);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [mcim_pkg::ADDR_W-1:0] paddr;
  logic [mcim_pkg::DATA_W-1:0] pwdata;
  logic [mcim_pkg::DATA_W-1:0] prdata;
  logic pready;

  mcim_in_if  in_ch();
  mcim_out_if out_ch();

  i2t_scoreboard sb;
  int rx_stall;
  int rx_cycle;

  motor_current_i2t_monitor_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: random single-cycle stalls, occasional long stalls and
  // periodic stretches with ready held high.
  initial begin
    out_ch.ready = 1'b0;
    rx_stall = 0;
    rx_cycle = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else if (rx_cycle[9:8] == 2'b11) begin
        out_ch.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 15))
          0: begin
            rx_stall = $urandom_range(1, 40);
            out_ch.ready <= 1'b0;
          end
          1, 2, 3: out_ch.ready <= 1'b0;
          default: out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.joint_out, out_ch.current_ma, out_ch.accumulated,
                        out_ch.offset_valid});
  end

  function automatic current_sample_t mk_sample(int j, int sample, bit pos, int duty);
    current_sample_t s;
    s.joint        = mcim_pkg::JOINT_W'(j);
    s.adc_sample   = mcim_pkg::SAMPLE_W'(sample);
    s.positive_dir = pos;
    s.duty         = mcim_pkg::DUTY_W'(duty);
    return s;
  endfunction

  function automatic current_sample_t random_sample();
    current_sample_t s;
    int v;
    s.joint        = mcim_pkg::JOINT_W'($urandom_range(0, mcim_pkg::JOINTS - 1));
    s.positive_dir = 1'($urandom_range(0, 1));
    v = int'(sb.offset[s.joint]);
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 65535));
      3:       v = mcim_pkg::OFFSET_SKIP;
      4, 5:    v = v + int'($urandom_range(0, 400)) - 200;
      default: v = v + int'($urandom_range(0, 12000));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    s.adc_sample = mcim_pkg::SAMPLE_W'(v);
    case ($urandom_range(0, 9))
      0:       s.duty = mcim_pkg::DUTY_W'($urandom_range(0, mcim_pkg::LOW_DUTY_MAX));
      1:       s.duty = mcim_pkg::DUTY_W'(mcim_pkg::LOW_DUTY_MAX + 1);
      2:       s.duty = mcim_pkg::DUTY_W'($urandom_range(mcim_pkg::LOW_DUTY_MAX + 1, 4095));
      3:       s.duty = {mcim_pkg::DUTY_W{1'b1}};
      default: s.duty = mcim_pkg::DUTY_W'($urandom_range(200, 1000));
    endcase
    return s;
  endfunction

  task automatic send_sample(input current_sample_t s);
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.joint        <= s.joint;
    in_ch.adc_sample   <= s.adc_sample;
    in_ch.positive_dir <= s.positive_dir;
    in_ch.duty         <= s.duty;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(s);
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Hold off until every expected result is back and the block is idle
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input logic [mcim_pkg::REG_IDX_W-1:0] idx,
                           input logic [mcim_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(input int n_items, input logic mode_sel);
    int burst;
    settle();
    apb_write(mcim_pkg::REG_MODE, mcim_pkg::DATA_W'(mode_sel));
    case ($urandom_range(0, 4))
      0:       apb_write(mcim_pkg::REG_LIMIT, 32'd0);
      1:       apb_write(mcim_pkg::REG_LIMIT, 32'd65535);
      2:       apb_write(mcim_pkg::REG_LIMIT, mcim_pkg::DATA_W'(mcim_pkg::LIMIT_RESET));
      3:       apb_write(mcim_pkg::REG_LIMIT, $urandom_range(0, 20000));
      default: apb_write(mcim_pkg::REG_LIMIT, $urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 4))
      0:       apb_write(mcim_pkg::REG_FACTOR, 32'd0);
      1:       apb_write(mcim_pkg::REG_FACTOR, 32'd65535);
      2, 3:    apb_write(mcim_pkg::REG_FACTOR, mcim_pkg::DATA_W'(mcim_pkg::FACTOR_RESET));
      default: apb_write(mcim_pkg::REG_FACTOR, $urandom_range(0, 65535));
    endcase
    burst = 0;
    for (int i = 0; i < n_items; i++) begin
      if (burst == 0) begin
        sender_gap(($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 15)));
        burst = ($urandom_range(0, 7) == 0) ? int'($urandom_range(30, 60))
                                            : int'($urandom_range(1, 20));
      end
      send_sample(random_sample());
      burst--;
    end
  endtask

  initial begin
    sb = new();
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.joint        = '0;
    in_ch.adc_sample   = '0;
    in_ch.positive_dir = 1'b0;
    in_ch.duty         = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(negedge clk);

    // Reset settings, low-pass mode: offset calibration and scaling corners
    send_sample(mk_sample(0, mcim_pkg::OFFSET_SKIP, 1, 500));   // skip value keeps offset pending
    send_sample(mk_sample(0, mcim_pkg::OFFSET_SKIP, 0, 0));     // low duty while pending
    send_sample(mk_sample(0, 3000, 1, 500));                    // offset latched here
    send_sample(mk_sample(0, 65535, 1, mcim_pkg::LOW_DUTY_MAX + 1));
    send_sample(mk_sample(0, 65535, 0, mcim_pkg::LOW_DUTY_MAX + 1));
    send_sample(mk_sample(0, 2000, 1, 4095));                   // below offset clamps to zero
    send_sample(mk_sample(0, 3500, 0, 4095));
    send_sample(mk_sample(0, 4000, 1, mcim_pkg::LOW_DUTY_MAX));
    send_sample(mk_sample(0, 4000, 1, mcim_pkg::LOW_DUTY_MAX + 2));
    send_sample(mk_sample(1, mcim_pkg::OFFSET_SKIP, 0, 700));
    send_sample(mk_sample(1, 0, 1, 500));                       // zero offset on joint 1
    send_sample(mk_sample(1, 65535, 1, 4095));
    send_sample(mk_sample(1, 1, 0, 4095));
    send_sample(mk_sample(1, 32768, 0, 1000));

    // i2t with zero limit and full-scale factor: accumulator saturates
    settle();
    apb_write(mcim_pkg::REG_MODE, mcim_pkg::DATA_W'(mcim_pkg::MODE_I2T));
    apb_write(mcim_pkg::REG_LIMIT, 32'd0);
    apb_write(mcim_pkg::REG_FACTOR, 32'd65535);
    send_sample(mk_sample(0, 65535, 1, mcim_pkg::LOW_DUTY_MAX + 1));
    send_sample(mk_sample(1, 4000, 0, 2000));
    send_sample(mk_sample(0, 100, 0, 0));

    // Limit at full scale: joint 0 accumulator drains, joint 1 current still exceeds it
    settle();
    apb_write(mcim_pkg::REG_LIMIT, 32'd65535);
    send_sample(mk_sample(0, 3000, 1, 500));
    send_sample(mk_sample(1, 20000, 0, 300));
    send_sample(mk_sample(1, 20000, 1, 300));

    // Zero factor, then back to low-pass from the i2t value
    settle();
    apb_write(mcim_pkg::REG_LIMIT, mcim_pkg::DATA_W'(mcim_pkg::LIMIT_RESET));
    apb_write(mcim_pkg::REG_FACTOR, 32'd0);
    send_sample(mk_sample(0, 65535, 1, 600));
    send_sample(mk_sample(1, 65535, 0, 50));
    settle();
    apb_write(mcim_pkg::REG_MODE, mcim_pkg::DATA_W'(mcim_pkg::MODE_LPF));
    apb_write(mcim_pkg::REG_FACTOR, mcim_pkg::DATA_W'(mcim_pkg::FACTOR_RESET));
    send_sample(mk_sample(0, 9000, 1, 500));
    send_sample(mk_sample(1, 9000, 0, 500));

    random_phase(110, mcim_pkg::MODE_LPF);
    random_phase(110, mcim_pkg::MODE_I2T);
    random_phase(110, mcim_pkg::MODE_LPF);
    random_phase(110, mcim_pkg::MODE_I2T);
    random_phase(110, mcim_pkg::MODE_I2T);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
